FILE: rtl/core/q24_pkg.sv
// q24_pkg: operation codes and the stage control struct of the fixed-point alu
// no dependencies; used by scoped names by the alu top level, q24_entry and q24_cell

package q24_pkg;

    localparam int unsigned FUNC_W = 4;
    localparam int unsigned DATA_W = 32;

    localparam logic [FUNC_W-1:0] FN_ADD  = 4'd0;
    localparam logic [FUNC_W-1:0] FN_SUB  = 4'd1;
    localparam logic [FUNC_W-1:0] FN_MUL  = 4'd2;
    localparam logic [FUNC_W-1:0] FN_DIV  = 4'd3;
    localparam logic [FUNC_W-1:0] FN_LT   = 4'd4;
    localparam logic [FUNC_W-1:0] FN_LE   = 4'd5;
    localparam logic [FUNC_W-1:0] FN_GT   = 4'd6;
    localparam logic [FUNC_W-1:0] FN_GE   = 4'd7;
    localparam logic [FUNC_W-1:0] FN_EQ   = 4'd8;
    localparam logic [FUNC_W-1:0] FN_NE   = 4'd9;
    localparam logic [FUNC_W-1:0] FN_MIN  = 4'd10;
    localparam logic [FUNC_W-1:0] FN_MAX  = 4'd11;
    localparam logic [FUNC_W-1:0] FN_INC  = 4'd12;
    localparam logic [FUNC_W-1:0] FN_DEC  = 4'd13;
    localparam logic [FUNC_W-1:0] FN_FINT = 4'd14;
    localparam logic [FUNC_W-1:0] FN_TINT = 4'd15;

    // control travelling alongside the divider data
    typedef struct packed {
        logic              valid;
        logic [FUNC_W-1:0] func;
        logic [DATA_W-1:0] res;   // result of every operation but divide and the compares
        logic              cmp;
        logic              dz;
        logic              neg;   // quotient sign
    } t_ctrl;

endpackage

FILE: rtl/core/q24_8_fixed_point_alu.sv
// q24_8_fixed_point_alu: signed fixed-point alu, pipelined with a chain of divide cells
// stages: entry stage, one cell per quotient bit, output register
// throughput one transfer per cycle; every operation runs down the same chain
// the whole pipe stalls while a result waits on i_m_tready
// synchronous active-low reset clears the valid bits only; depends on q24_pkg,
// q24_entry and q24_cell

module q24_8_fixed_point_alu #(
    parameter int unsigned FRAC_BITS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // operand_a [31:0], operand_b [63:32]
    input  logic [3:0]  i_s_tuser,   // func [3:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata    // result_value [31:0], compare_flag [32],
                                     // divide_by_zero [33], zero fill [39:34]
);

    localparam int unsigned W  = q24_pkg::DATA_W;
    localparam int unsigned NB = W + FRAC_BITS;   // quotient bits, one cell each

    // chain wiring, index 0 is the entry stage output
    q24_pkg::t_ctrl w_ctrl [0:NB];
    logic [W-1:0]   w_dvs  [0:NB];
    logic [W-1:0]   w_rem  [0:NB];
    logic [NB-1:0]  w_dvd  [0:NB];
    logic [NB-1:0]  w_quo  [0:NB];

    logic           w_en;
    logic           r_valid;
    logic [W-1:0]   r_res;
    logic           r_cmp, r_dz;
    logic [W-1:0]   w_q32;
    logic [W-1:0]   n_res;

    // whole pipe moves whenever the output register is free or being drained
    assign w_en       = !r_valid || i_m_tready;
    assign o_s_tready = w_en;

    q24_entry #(.FRAC_BITS(FRAC_BITS)) u_entry (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_func  (i_s_tuser),
        .i_a     (i_s_tdata[31:0]),
        .i_b     (i_s_tdata[63:32]),
        .o_ctrl  (w_ctrl[0]),
        .o_dvs   (w_dvs[0]),
        .o_dvd   (w_dvd[0])
    );

    // partial remainder and quotient start empty
    assign w_rem[0] = '0;
    assign w_quo[0] = '0;

    genvar g;
    generate
        for (g = 0; g < NB; g++) begin : g_cell
            q24_cell #(.NB(NB)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (w_en),
                .i_ctrl  (w_ctrl[g]),
                .i_dvs   (w_dvs[g]),
                .i_rem   (w_rem[g]),
                .i_dvd   (w_dvd[g]),
                .i_quo   (w_quo[g]),
                .o_ctrl  (w_ctrl[g+1]),
                .o_dvs   (w_dvs[g+1]),
                .o_rem   (w_rem[g+1]),
                .o_dvd   (w_dvd[g+1]),
                .o_quo   (w_quo[g+1])
            );
        end
    endgenerate

    // signed quotient wrapped to 32 bits, truncated toward zero
    assign w_q32 = w_ctrl[NB].neg ? (~w_quo[NB][W-1:0] + 1'b1) : w_quo[NB][W-1:0];

    always_comb begin
        n_res = w_ctrl[NB].res;
        if (w_ctrl[NB].func == q24_pkg::FN_DIV) begin
            n_res = w_ctrl[NB].dz ? '0 : w_q32;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_en) begin
            r_valid <= w_ctrl[NB].valid;
            r_res   <= n_res;
            r_cmp   <= w_ctrl[NB].cmp;
            r_dz    <= w_ctrl[NB].dz;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {6'd0, r_dz, r_cmp, r_res};

endmodule

FILE: rtl/core/q24_entry.sv
// q24_entry: first stage, registers the results of the operations other than divide,
// including the multiplier, and prepares magnitudes for the divide chain; uses q24_pkg

module q24_entry #(
    parameter int unsigned FRAC_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic [q24_pkg::FUNC_W-1:0]          i_func,
    input  logic signed [q24_pkg::DATA_W-1:0]   i_a,
    input  logic signed [q24_pkg::DATA_W-1:0]   i_b,
    output q24_pkg::t_ctrl                      o_ctrl,
    output logic [q24_pkg::DATA_W-1:0]          o_dvs,
    output logic [q24_pkg::DATA_W+FRAC_BITS-1:0] o_dvd
);

    localparam int unsigned W  = q24_pkg::DATA_W;
    localparam int unsigned NB = W + FRAC_BITS;

    q24_pkg::t_ctrl    n_ctrl, r_ctrl;
    logic signed [2*W-1:0] w_prod;
    logic [W-1:0]      r_prod;
    logic [W-1:0]      r_dvs;
    logic [NB-1:0]     r_dvd;
    logic [W-1:0]      w_abs_a, w_abs_b;

    assign w_prod  = i_a * i_b;
    assign w_abs_a = i_a[W-1] ? (~i_a + 1'b1) : i_a;
    assign w_abs_b = i_b[W-1] ? (~i_b + 1'b1) : i_b;

    always_comb begin
        n_ctrl       = '0;
        n_ctrl.valid = i_valid;
        n_ctrl.func  = i_func;
        n_ctrl.neg   = i_a[W-1] ^ i_b[W-1];
        unique case (i_func)
            q24_pkg::FN_ADD:  n_ctrl.res = i_a + i_b;
            q24_pkg::FN_SUB:  n_ctrl.res = i_a - i_b;
            q24_pkg::FN_MUL:  n_ctrl.res = '0;
            q24_pkg::FN_DIV:  n_ctrl.dz  = (i_b == '0);
            q24_pkg::FN_LT:   n_ctrl.cmp = (i_a < i_b);
            q24_pkg::FN_LE:   n_ctrl.cmp = (i_a <= i_b);
            q24_pkg::FN_GT:   n_ctrl.cmp = (i_a > i_b);
            q24_pkg::FN_GE:   n_ctrl.cmp = (i_a >= i_b);
            q24_pkg::FN_EQ:   n_ctrl.cmp = (i_a == i_b);
            q24_pkg::FN_NE:   n_ctrl.cmp = (i_a != i_b);
            q24_pkg::FN_MIN:  n_ctrl.res = (i_a > i_b) ? i_b : i_a;
            q24_pkg::FN_MAX:  n_ctrl.res = (i_a < i_b) ? i_b : i_a;
            q24_pkg::FN_INC:  n_ctrl.res = i_a + 1'b1;
            q24_pkg::FN_DEC:  n_ctrl.res = i_a - 1'b1;
            q24_pkg::FN_FINT: n_ctrl.res = i_a << FRAC_BITS;
            q24_pkg::FN_TINT: n_ctrl.res = i_a >>> FRAC_BITS;
            default:          n_ctrl.res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctrl <= n_ctrl;
            r_prod <= w_prod[FRAC_BITS+W-1:FRAC_BITS];
            r_dvs  <= w_abs_b;
            r_dvd  <= {w_abs_a, {FRAC_BITS{1'b0}}};
        end
    end

    // product joins the result field after its register
    always_comb begin
        o_ctrl = r_ctrl;
        if (r_ctrl.func == q24_pkg::FN_MUL) begin
            o_ctrl.res = r_prod;
        end
    end

    assign o_dvs = r_dvs;
    assign o_dvd = r_dvd;

endmodule

FILE: rtl/core/q24_cell.sv
// q24_cell: one restoring-division step, produces one quotient bit per cycle while i_en is high
// and hands remainder, dividend and control to the next cell; uses q24_pkg

module q24_cell #(
    parameter int unsigned NB = 40
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  q24_pkg::t_ctrl              i_ctrl,
    input  logic [q24_pkg::DATA_W-1:0]  i_dvs,
    input  logic [q24_pkg::DATA_W-1:0]  i_rem,
    input  logic [NB-1:0]               i_dvd,
    input  logic [NB-1:0]               i_quo,
    output q24_pkg::t_ctrl              o_ctrl,
    output logic [q24_pkg::DATA_W-1:0]  o_dvs,
    output logic [q24_pkg::DATA_W-1:0]  o_rem,
    output logic [NB-1:0]               o_dvd,
    output logic [NB-1:0]               o_quo
);

    localparam int unsigned W = q24_pkg::DATA_W;

    q24_pkg::t_ctrl r_ctrl;
    logic [W-1:0]   r_dvs, r_rem;
    logic [NB-1:0]  r_dvd, r_quo;
    logic [W:0]     w_trial, w_diff;
    logic           w_ge;

    assign w_trial = {i_rem, i_dvd[NB-1]};
    assign w_diff  = w_trial - {1'b0, i_dvs};
    assign w_ge    = (w_trial >= {1'b0, i_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl.valid <= 1'b0;
        end else if (i_en) begin
            r_ctrl <= i_ctrl;
            r_dvs  <= i_dvs;
            r_rem  <= w_ge ? w_diff[W-1:0] : w_trial[W-1:0];
            r_dvd  <= {i_dvd[NB-2:0], 1'b0};
            r_quo  <= {i_quo[NB-2:0], w_ge};
        end
    end

    assign o_ctrl = r_ctrl;
    assign o_dvs  = r_dvs;
    assign o_rem  = r_rem;
    assign o_dvd  = r_dvd;
    assign o_quo  = r_quo;

endmodule

FILE: rtl/core/q24_chk.sv
// q24_chk: port-level checks of the fixed-point alu, bound to the top level
// depends on q24_8_fixed_point_alu ports only

module q24_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] o_m_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // reset empties the output
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // an empty or draining output never blocks input
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid || i_m_tready |-> o_s_tready)
        else $error("input blocked while output free");

    // divide by zero gives zero result and no compare flag
    a_dz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[33] |-> !o_m_tdata[32] && o_m_tdata[31:0] == 32'd0)
        else $error("divide by zero result not clean");

endmodule

bind q24_8_fixed_point_alu q24_chk u_q24_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
